// ===== rtl/rdd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared constants and a helper for the reply deframer and decoder.
// ----------------------------------------------------------------------------
package rdd_pkg;

	localparam int unsigned CntW = 5;

	// input item command
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// result kinds
	localparam logic [2:0] KIND_UNKNOWN = 3'd0;
	localparam logic [2:0] KIND_STATUS  = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_TRACK   = 3'd3;
	localparam logic [2:0] KIND_STATION = 3'd4;
	localparam logic [2:0] KIND_ADDRESS = 3'd5;
	localparam logic [2:0] KIND_XOR_ERR = 3'd6;

	// header bytes
	localparam logic [7:0] HDR_STATUS  = 8'h01;
	localparam logic [7:0] HDR_VERSION = 8'h02;
	localparam logic [7:0] HDR_TRACK   = 8'h61;
	localparam logic [7:0] HDR_STATION = 8'h63;
	localparam logic [7:0] HDR_ADDRESS = 8'hF2;

	localparam logic [7:0] SUB_STATION = 8'h21;
	localparam logic [7:0] SUB_ADDRESS = 8'h01;

	localparam logic [7:0] STATUS_MIN = 8'h01;
	localparam logic [7:0] STATUS_MAX = 8'h06;
	localparam logic [7:0] TRACK_MAX  = 8'h02;

	localparam logic [15:0] TIMEOUT_RST = 16'd300;

	// two-digit BCD to binary: lo + 10*hi, 10*hi = 8*hi + 2*hi
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'd0, v[7:4]};
		return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
	endfunction

endpackage

// ===== rtl/reply_deframer_and_decoder.sv =====
// ----------------------------------------------------------------------------
// reply_deframer_and_decoder
// Frames received reply bytes, checks the XOR and decodes each frame.
// ----------------------------------------------------------------------------
// Takes one beat per clock (byte or idle tick) while not stalled and returns
// one decoded result per completed frame; the closing byte passes through the
// input register, then the result register. A frame's length is the header's
// low nibble plus two; a partial frame is dropped when a byte arrives after at
// least timeout_q idle ticks. Input is stalled only while a result is ready to
// leave and the result register is still held by out_stall.
module reply_deframer_and_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [4:0]  frame_length,
	output logic [7:0]  code,
	output logic [7:0]  major_value,
	output logic [7:0]  minor_value
);
	import rdd_pkg::*;

	logic [15:0]     timeout_q;
	logic            valid_s1;
	logic            cmd_s1;
	logic [7:0]      byte_s1;

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] exp_len_q;
	logic [7:0]      xor_q;
	logic [15:0]     idle_q;
	logic [7:0]      hb0_q, hb1_q, hb2_q;

	logic            out_valid_q;
	logic [2:0]      kind_q;
	logic [4:0]      len_q;
	logic [7:0]      code_q, major_q, minor_q;

	logic [CntW-1:0] cnt_eff, cnt_inc;
	logic [7:0]      xor_n, hb1_n, hb2_n;
	logic            is_byte, start, done, advance;
	logic [2:0]      kind_n;
	logic [7:0]      code_n, major_n, minor_n;

	always_comb begin
		is_byte = valid_s1 && (cmd_s1 == CMD_BYTE);
		// stale partial frame restarts from this byte
		cnt_eff = (count_q != '0 && idle_q >= timeout_q) ? '0 : count_q;
		start   = (cnt_eff == '0);
		cnt_inc = cnt_eff + CntW'(1);
		xor_n   = xor_q ^ byte_s1;
		hb1_n   = (cnt_eff == CntW'(1)) ? byte_s1 : hb1_q;
		hb2_n   = (cnt_eff == CntW'(2)) ? byte_s1 : hb2_q;
		done    = is_byte && !start && (cnt_inc >= exp_len_q);
	end

	always_comb begin
		kind_n  = KIND_UNKNOWN;
		code_n  = '0;
		major_n = '0;
		minor_n = '0;
		if (xor_n != '0) begin
			kind_n = KIND_XOR_ERR;
		end else begin
			case (hb0_q)
				HDR_STATUS: begin
					if (hb1_n inside {[STATUS_MIN:STATUS_MAX]}) begin
						kind_n = KIND_STATUS;
						code_n = hb1_n;
					end
				end
				HDR_VERSION: begin
					kind_n  = KIND_VERSION;
					major_n = bcd_to_bin(hb1_n);
					minor_n = bcd_to_bin(hb2_n);
				end
				HDR_TRACK: begin
					if (hb1_n <= TRACK_MAX) begin
						kind_n = KIND_TRACK;
						code_n = hb1_n;
					end
				end
				HDR_STATION: begin
					if (hb1_n == SUB_STATION) begin
						kind_n  = KIND_STATION;
						major_n = {4'd0, hb2_n[7:4]};
						minor_n = {4'd0, hb2_n[3:0]};
					end
				end
				HDR_ADDRESS: begin
					if (hb1_n == SUB_ADDRESS) begin
						kind_n = KIND_ADDRESS;
						code_n = hb2_n;
					end
				end
				default: begin
					kind_n = KIND_UNKNOWN;
				end
			endcase
		end
	end

	// a beat moves on unless it makes a result while the last one is held
	assign advance  = valid_s1 && !(done && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			exp_len_q <= '0;
			xor_q     <= '0;
			idle_q    <= '0;
		end else if (advance) begin
			if (cmd_s1 == CMD_TICK) begin
				if (idle_q != '1)
					idle_q <= idle_q + 16'd1;
			end else begin
				idle_q <= '0;
				if (start) begin
					exp_len_q <= CntW'({1'b0, byte_s1[3:0]}) + CntW'(2);
					xor_q     <= byte_s1;
					count_q   <= CntW'(1);
				end else if (done) begin
					xor_q   <= '0;
					count_q <= '0;
				end else begin
					xor_q   <= xor_n;
					count_q <= cnt_inc;
				end
			end
		end
	end

	// header bytes need no reset: decode reads only bytes of the same frame
	always_ff @(posedge clk) begin
		if (advance && is_byte) begin
			if (start)
				hb0_q <= byte_s1;
			hb1_q <= hb1_n;
			hb2_q <= hb2_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			kind_q  <= kind_n;
			len_q   <= exp_len_q;
			code_q  <= code_n;
			major_q <= major_n;
			minor_q <= minor_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign frame_length = len_q;
	assign code         = code_q;
	assign major_value  = major_q;
	assign minor_value  = minor_q;

endmodule

// ===== tb/tb_reply_deframer_and_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_reply_deframer_and_decoder
// Drives bytes and idle ticks into the reply deframer, predicts each decoded
// frame with a behavioral deframer and checks every reply field by field.
// A directed script comes first, then random frames, mostly well-formed, with
// noise under several timeouts and idle mixes.
// ----------------------------------------------------------------------------
module tb_reply_deframer_and_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import rdd_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_BEATS = 1150;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] length;
		logic [7:0] code;
		logic [7:0] major;
		logic [7:0] minor;
	} reply_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t    op;
		logic [15:0] val;
		logic       typed;
		reply_t     want;
	} dir_row_t;

	localparam reply_t NO_REPLY = '0;

	// typed rows carry the reply by hand, the rest go through the predictor
	localparam dir_row_t SCRIPT [26] = '{
		'{ROW_BYTE, 16'h0001, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0001, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0000, 1'b1, '{KIND_STATUS, 5'd3, 8'd1, 8'd0, 8'd0}},
		'{ROW_BYTE, 16'h0002, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00FF, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00FF, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0002, 1'b1, '{KIND_VERSION, 5'd4, 8'd0, 8'd165, 8'd165}},
		'{ROW_BYTE, 16'h0061, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0002, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0063, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0063, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0021, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00A5, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0000, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00E7, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00F2, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0001, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h00FF, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h000C, 1'b1, '{KIND_ADDRESS, 5'd4, 8'd255, 8'd0, 8'd0}},
		'{ROW_BYTE, 16'h0000, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0055, 1'b1, '{KIND_XOR_ERR, 5'd2, 8'd0, 8'd0, 8'd0}},
		'{ROW_CFG,  16'h0001, 1'b0, NO_REPLY},
		// stale partial frame: one tick with timeout 1 drops it
		'{ROW_BYTE, 16'h0001, 1'b0, NO_REPLY},
		'{ROW_TICK, 16'h00C3, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0000, 1'b0, NO_REPLY},
		'{ROW_BYTE, 16'h0000, 1'b0, NO_REPLY}
	};

	localparam int SRC_IDLE_PCT [4] = '{0, 88, 0, 36};
	localparam int SNK_STALL_PCT [4] = '{0, 0, 88, 36};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [4:0]  frame_length;
	logic [7:0]  code;
	logic [7:0]  major_value;
	logic [7:0]  minor_value;

	reply_deframer_and_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.frame_length (frame_length),
		.code         (code),
		.major_value  (major_value),
		.minor_value  (minor_value)
	);

	// predictor state
	logic [15:0] rx_timeout = TIMEOUT_RST;
	logic [4:0]  frm_count = '0;
	logic [4:0]  frm_len = '0;
	logic [7:0]  frm_xor = '0;
	logic [7:0]  frm_head [3] = '{8'd0, 8'd0, 8'd0};
	logic [15:0] idle_cnt = '0;

	reply_t replies_due [$];
	int     errors = 0;
	int     beats_sent = 0;
	int     src_idle_pct = 0;
	int     snk_stall_pct = 0;
	int     quiet_cycles = 0;

	function automatic logic [7:0] bcd_value(input logic [7:0] v);
		return {4'd0, v[3:0]} + 8'(v[7:4]) * 8'd10;
	endfunction

	// advances the deframer by one beat; returns 1 when a frame completes
	function automatic bit deframe_beat(input logic c, input logic [7:0] b,
			output reply_t r);
		r = '0;
		if (c == CMD_TICK) begin
			if (idle_cnt != 16'hFFFF)
				idle_cnt++;
			return 1'b0;
		end
		if (frm_count != 0 && idle_cnt >= rx_timeout) begin
			frm_count = '0;
			frm_xor = '0;
		end
		idle_cnt = '0;
		if (frm_count == 0) begin
			frm_len = {1'b0, b[3:0]} + 5'd2;
			frm_head[0] = b;
			frm_xor = b;
			frm_count = 5'd1;
			return 1'b0;
		end
		if (frm_count < 3)
			frm_head[frm_count[1:0]] = b;
		frm_xor ^= b;
		frm_count++;
		if (frm_count < frm_len)
			return 1'b0;

		r.length = frm_len;
		if (frm_xor != 0) begin
			r.kind = KIND_XOR_ERR;
		end else begin
			case (frm_head[0])
				HDR_STATUS: if (frm_head[1] >= STATUS_MIN && frm_head[1] <= STATUS_MAX) begin
					r.kind = KIND_STATUS;
					r.code = frm_head[1];
				end
				HDR_VERSION: begin
					r.kind = KIND_VERSION;
					r.major = bcd_value(frm_head[1]);
					r.minor = bcd_value(frm_head[2]);
				end
				HDR_TRACK: if (frm_head[1] <= TRACK_MAX) begin
					r.kind = KIND_TRACK;
					r.code = frm_head[1];
				end
				HDR_STATION: if (frm_head[1] == SUB_STATION) begin
					r.kind = KIND_STATION;
					r.major = {4'd0, frm_head[2][7:4]};
					r.minor = {4'd0, frm_head[2][3:0]};
				end
				HDR_ADDRESS: if (frm_head[1] == SUB_ADDRESS) begin
					r.kind = KIND_ADDRESS;
					r.code = frm_head[2];
				end
				default: ;
			endcase
		end
		frm_count = '0;
		frm_xor = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_item(input logic c, input logic [7:0] b, input logic typed,
			input reply_t want);
		reply_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (deframe_beat(c, b, r))
			replies_due.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// drain all replies, then give the pipeline time to empty after trailing ticks
	task automatic settle();
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		rx_timeout = v;
	endtask

	task automatic send_random();
		logic [7:0] frame [17];
		logic [7:0] chk;
		int n;
		if ($urandom_range(0, 9) == 0) begin
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
			return;
		end
		case ($urandom_range(0, 9))
			0: frame[0] = HDR_STATUS;
			1: frame[0] = HDR_VERSION;
			2: frame[0] = HDR_TRACK;
			3: frame[0] = HDR_STATION;
			4: frame[0] = HDR_ADDRESS;
			default: frame[0] = 8'($urandom_range(0, 255));
		endcase
		n = int'(frame[0][3:0]) + 2;
		chk = frame[0];
		for (int i = 1; i < n; i++) begin
			frame[i] = 8'($urandom_range(0, 255));
			if (i == n - 1) begin
				// mostly a good check byte, now and then a corrupted one
				frame[i] = chk;
				if ($urandom_range(0, 7) == 0)
					frame[i] ^= 8'($urandom_range(1, 255));
			end else if (i == 1 && $urandom_range(0, 3) != 0) begin
				case (frame[0])
					HDR_STATUS:  frame[i] = 8'($urandom_range(0, 7));
					HDR_TRACK:   frame[i] = 8'($urandom_range(0, 3));
					HDR_STATION: frame[i] = SUB_STATION;
					HDR_ADDRESS: frame[i] = SUB_ADDRESS;
					default: ;
				endcase
			end
			chk ^= frame[i];
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4))
					send_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, NO_REPLY);
			send_item(CMD_BYTE, frame[i], 1'b0, NO_REPLY);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < snk_stall_pct);

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply kind %0d length %0d", $time, kind, frame_length);
				errors++;
			end else begin
				want = replies_due.pop_front();
				check_field("kind", want.kind, kind);
				check_field("frame_length", want.length, frame_length);
				check_field("code", want.code, code);
				check_field("major_value", want.major, major_value);
				check_field("minor_value", want.minor, minor_value);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int base;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		cmd = CMD_BYTE;
		data_byte = '0;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].op == ROW_CFG) begin
				settle();
				write_timeout(SCRIPT[i].val);
			end else begin
				send_item(SCRIPT[i].op == ROW_TICK ? CMD_TICK : CMD_BYTE, SCRIPT[i].val[7:0],
					SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		base = beats_sent;
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: write_timeout(TIMEOUT_RST);
				1: write_timeout(16'd1);
				2: write_timeout(16'd2);
				3: write_timeout(16'hFFFF);
				4: write_timeout(16'd7);
				5: write_timeout(16'd3);
				6: write_timeout(16'($urandom_range(1, 65535)));
				default: write_timeout(16'd1);
			endcase
			src_idle_pct = SRC_IDLE_PCT[p % 4];
			snk_stall_pct = SNK_STALL_PCT[p % 4];
			while (beats_sent < base + (p + 1) * (RANDOM_BEATS / NUM_PHASES))
				send_random();
		end

		settle();
		repeat (8) @(negedge clk);
		if (errors == 0 && replies_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rdd_pkg.sv
rtl/reply_deframer_and_decoder.sv
tb/tb_reply_deframer_and_decoder.sv
